FILE: hdl/rsas_pkg.sv
package rsas_pkg;

	localparam int DEPTH  = 1024;
	localparam int DATA_W = 32;
	localparam int OP_W   = 2;
	localparam int POS_W  = 10;
	localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W  = $clog2(DEPTH + 1);
	// signed bound register: holds 0..DEPTH and -1
	localparam int PTR_W  = CNT_W + 1;

	typedef enum logic [OP_W-1:0] {
		OP_APPEND = 2'd0,
		OP_SEARCH = 2'd1,
		OP_CLEAR  = 2'd2
	} op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_P_CHK,
		ST_P_MID,
		ST_P_LEFT,
		ST_P_RIGHT,
		ST_P_LO,
		ST_R_ZERO,
		ST_R_FIRST,
		ST_R_LAST,
		ST_S_CHK,
		ST_S_MID,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic lt;
		logic eq;
		logic gt;
	} cmp_res_t;

	typedef struct packed {
		logic              we;
		logic [IDX_W-1:0]  waddr;
		logic [DATA_W-1:0] wdata;
		logic [IDX_W-1:0]  raddr;
	} mem_req_t;

endpackage

FILE: hdl/rsas_ram.sv
module rsas_ram #(
	parameter int DEPTH_P = 1024,
	parameter int WIDTH_P = 32,
	parameter int ADDR_W  = (DEPTH_P > 1) ? $clog2(DEPTH_P) : 1
) (
	input  logic               clk,
	input  logic               we,
	input  logic [ADDR_W-1:0]  waddr,
	input  logic [WIDTH_P-1:0] wdata,
	input  logic [ADDR_W-1:0]  raddr,
	output logic [WIDTH_P-1:0] rdata
);

	logic [WIDTH_P-1:0] mem [DEPTH_P];
	logic [WIDTH_P-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rd_q <= mem[raddr];
	end

	assign rdata = rd_q;

endmodule

FILE: hdl/rsas_cmp.sv
module rsas_cmp (
	input  logic signed [rsas_pkg::DATA_W-1:0] a,
	input  logic signed [rsas_pkg::DATA_W-1:0] b,
	output rsas_pkg::cmp_res_t                 res
);

	import rsas_pkg::*;

	// one signed magnitude compare, shared by both searches
	always_comb begin
		res.lt = (a < b);
		res.eq = (a == b);
		res.gt = (a > b);
	end

endmodule

FILE: hdl/rsas_ctrl.sv
module rsas_ctrl (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [rsas_pkg::OP_W-1:0]          in_op,
	input  logic [rsas_pkg::DATA_W-1:0]        in_value,
	input  logic [rsas_pkg::DATA_W-1:0]        rd_data,
	input  rsas_pkg::cmp_res_t                 cmp,
	output logic signed [rsas_pkg::DATA_W-1:0] cmp_a,
	output rsas_pkg::mem_req_t                 mem,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic                               found,
	output logic [rsas_pkg::POS_W-1:0]         position
);

	import rsas_pkg::*;

	state_t                    state_q, state_d;
	logic [CNT_W-1:0]          count_q;
	logic signed [PTR_W-1:0]   lo_q, hi_q;
	logic [IDX_W-1:0]          mid_q, piv_q;
	logic signed [DATA_W-1:0]  target_q, emid_q;
	logic                      ge0_q, found_q;
	logic [POS_W-1:0]          pos_q;

	logic [PTR_W:0]            mid_sum;
	logic [IDX_W-1:0]          mid_c, mid_m1;
	logic [CNT_W-1:0]          mid_p1;
	logic                      has_left, has_right, range_empty, range_one;
	logic                      accept;

	assign accept = in_valid && in_ready;

	assign mid_sum     = {lo_q[PTR_W-1], lo_q} + {hi_q[PTR_W-1], hi_q};
	assign mid_c       = mid_sum[IDX_W:1];
	assign mid_m1      = mid_q - IDX_W'(1);
	assign mid_p1      = CNT_W'(mid_q) + CNT_W'(1);
	assign has_left    = (mid_q != '0);
	assign has_right   = (mid_p1 < count_q);
	assign range_empty = (lo_q > hi_q);
	assign range_one   = (lo_q == hi_q);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && in_op == OP_SEARCH) begin
					state_d = (count_q == '0) ? ST_DONE : ST_P_CHK;
				end
			end
			ST_P_CHK: begin
				priority if (range_empty) state_d = ST_DONE;
				else if (range_one)       state_d = ST_R_ZERO;
				else                      state_d = ST_P_MID;
			end
			ST_P_MID: begin
				priority if (has_left) state_d = ST_P_LEFT;
				else if (has_right)    state_d = ST_P_RIGHT;
				else                   state_d = ST_P_LO;
			end
			ST_P_LEFT: begin
				priority if (cmp.lt) state_d = ST_R_ZERO;
				else if (has_right)  state_d = ST_P_RIGHT;
				else                 state_d = ST_P_LO;
			end
			ST_P_RIGHT: state_d = cmp.gt ? ST_R_ZERO : ST_P_LO;
			ST_P_LO:    state_d = ST_P_CHK;
			ST_R_ZERO:  state_d = ST_R_FIRST;
			ST_R_FIRST: state_d = ST_R_LAST;
			ST_R_LAST:  state_d = ST_S_CHK;
			ST_S_CHK:   state_d = range_empty ? ST_DONE : ST_S_MID;
			ST_S_MID:   state_d = cmp.eq ? ST_DONE : ST_S_CHK;
			ST_DONE: begin
				if (out_ready) state_d = ST_IDLE;
			end
			default:    state_d = ST_IDLE;
		endcase
	end

	// outputs and read address
	always_comb begin
		in_ready  = 1'b0;
		out_valid = 1'b0;
		mem.raddr = '0;
		cmp_a     = target_q;
		unique case (state_q)
			ST_IDLE: in_ready = 1'b1;
			ST_P_CHK: mem.raddr = mid_c;
			ST_P_MID: begin
				cmp_a = emid_q;
				priority if (has_left) mem.raddr = mid_m1;
				else if (has_right)    mem.raddr = mid_p1[IDX_W-1:0];
				else                   mem.raddr = lo_q[IDX_W-1:0];
			end
			ST_P_LEFT: begin
				cmp_a = emid_q;
				mem.raddr = has_right ? mid_p1[IDX_W-1:0] : lo_q[IDX_W-1:0];
			end
			ST_P_RIGHT: begin
				cmp_a = emid_q;
				mem.raddr = lo_q[IDX_W-1:0];
			end
			ST_P_LO:    cmp_a = emid_q;
			ST_R_ZERO:  mem.raddr = '0;
			ST_R_FIRST: mem.raddr = piv_q;
			ST_S_CHK:   mem.raddr = mid_c;
			ST_DONE:    out_valid = 1'b1;
			default: ;
		endcase
	end

	assign mem.we    = accept && (in_op == OP_APPEND) && (count_q < CNT_W'(DEPTH));
	assign mem.waddr = count_q[IDX_W-1:0];
	assign mem.wdata = in_value;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			if (mem.we) begin
				count_q <= count_q + CNT_W'(1);
			end else if (accept && in_op == OP_CLEAR) begin
				count_q <= '0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				target_q <= $signed(in_value);
				found_q  <= 1'b0;
				pos_q    <= '0;
				lo_q     <= '0;
				hi_q     <= $signed(PTR_W'(count_q) - PTR_W'(1));
			end
			ST_P_CHK: begin
				mid_q <= mid_c;
				piv_q <= lo_q[IDX_W-1:0];
			end
			ST_P_MID: emid_q <= $signed(rd_data);
			ST_P_LEFT: piv_q <= mid_m1;
			ST_P_RIGHT: piv_q <= mid_q;
			ST_P_LO: begin
				// first element above the middle one: the pivot lies to the left
				if (cmp.lt) hi_q <= $signed(PTR_W'(mid_q) - PTR_W'(1));
				else        lo_q <= $signed(PTR_W'(mid_q) + PTR_W'(1));
			end
			ST_R_FIRST: ge0_q <= !cmp.lt;
			ST_R_LAST: begin
				if (ge0_q && !cmp.gt) begin
					lo_q <= '0;
					hi_q <= $signed(PTR_W'(piv_q));
				end else begin
					lo_q <= $signed(PTR_W'(piv_q) + PTR_W'(1));
					hi_q <= $signed(PTR_W'(count_q) - PTR_W'(1));
				end
			end
			ST_S_CHK: mid_q <= mid_c;
			ST_S_MID: begin
				priority if (cmp.eq) begin
					found_q <= 1'b1;
					pos_q   <= POS_W'(mid_q);
				end else if (cmp.gt) begin
					lo_q <= $signed(PTR_W'(mid_q) + PTR_W'(1));
				end else begin
					hi_q <= $signed(PTR_W'(mid_q) - PTR_W'(1));
				end
			end
			default: ;
		endcase
	end

	assign found    = found_q;
	assign position = pos_q;

endmodule

FILE: hdl/rotated_sorted_array_search_top.sv
// append and clear words leave the sequencer idle; the block is ready again on the next cycle
// a search runs pivot steps, a half selection and then lookup probes up to the result word,
// each paced by the single read port of the element memory
// one search in flight at a time; the result word is held until taken, input resumes next cycle
// arst_n clears the sequencer and the element count; memory contents are not cleared
module rotated_sorted_array_search_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // value[31:0]
	input  logic [1:0]  s_tuser,   // operation[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // position[9:0], zero fill [15:10]
	output logic        m_tuser    // found[0]
);

	import rsas_pkg::*;

	mem_req_t                 mem;
	cmp_res_t                 cmp;
	logic [DATA_W-1:0]        rd_data;
	logic signed [DATA_W-1:0] cmp_a;
	logic [POS_W-1:0]         position;

	// element storage, one write and one registered read per cycle
	rsas_ram #(
		.DEPTH_P (DEPTH),
		.WIDTH_P (DATA_W)
	) u_ram (
		.clk   (clk),
		.we    (mem.we),
		.waddr (mem.waddr),
		.wdata (mem.wdata),
		.raddr (mem.raddr),
		.rdata (rd_data)
	);

	// the one comparator; the b side is always the word just read
	rsas_cmp u_cmp (
		.a   (cmp_a),
		.b   ($signed(rd_data)),
		.res (cmp)
	);

	// sequencer: pivot search, half selection, then lookup
	rsas_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_op     (s_tuser),
		.in_value  (s_tdata),
		.rd_data   (rd_data),
		.cmp       (cmp),
		.cmp_a     (cmp_a),
		.mem       (mem),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.found     (m_tuser),
		.position  (position)
	);

	assign m_tdata = {(16 - POS_W)'(0), position};

	// never taking a word while a result is still pending
	assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("input taken while result pending");

	// a search always takes the sequencer out of idle in the cycle after it is accepted
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tuser == OP_SEARCH) |=> !s_tready)
		else $error("search did not start");

	// a miss reports position zero
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser) |-> (m_tdata == '0))
		else $error("nonzero position on miss");

	// after the result word is taken the block is idle again
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready) |=> (s_tready && !m_tvalid))
		else $error("not idle after result");

endmodule
